/* sv/pli_pkg.sv */
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants for the piecewise linear interpolator: table geometry,
// data widths and operation codes.
// ----------------------------------------------------------------------------
package pli_pkg;

  // Table geometry.
  localparam int MAX_POINTS = 64;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CNT_W      = AW + 1;

  // Field widths.
  localparam int VAL_W = 32;
  localparam int CFG_W = 7;

  // Operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

/* sv/piecewise_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Table of ascending supporting points with a value at each point. Loads
// write one entry; queries return the linear interpolation in Q16.16.
// ----------------------------------------------------------------------------
// A load transfer writes one table entry and gives no result. A query
// transfer scans the table one entry per cycle through the abscissa
// memory's single read port, reads both ends of the chosen interval from
// the ordinate memory, forms the product in one 32 x 32 multiply and then
// runs a restoring division, one quotient bit per cycle. A zero-width
// interval skips the division. A query ends out of range when no interval
// encloses its point, or when points_in_use, capped at 64, is below 2.
// A result waits while the previous one is still stalled in the output
// register. One item is in work at a time: in_stall is high from
// acceptance of a query until its result is placed in the output register,
// which then waits for the receiver while the next item is taken. Table
// contents are undefined until loaded.
module piecewise_linear_interpolator (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration
  input  logic                        cfg_wr_en,
  input  logic [pli_pkg::CFG_W-1:0]   cfg_wr_data,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [pli_pkg::AW-1:0]      in_entry_index,
  input  logic signed [pli_pkg::VAL_W-1:0] in_point_x,
  input  logic signed [pli_pkg::VAL_W-1:0] in_point_y,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [pli_pkg::VAL_W-1:0] out_value,
  output logic                        out_out_of_range,
  output logic [pli_pkg::AW-1:0]      out_interval
);
  import pli_pkg::*;

  localparam int DCNT_W = $clog2(VAL_W);

  // State codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RD0  = 3'd2;
  localparam logic [2:0] ST_RD1  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_PROD = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  // Memories and their registered read data.
  logic [VAL_W-1:0] abscissa_mem [MAX_POINTS];
  logic [VAL_W-1:0] ordinate_mem [MAX_POINTS];
  logic [VAL_W-1:0] ax_q;
  logic [VAL_W-1:0] oy_q;

  // Control and datapath registers.
  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  pin_r;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [VAL_W-1:0]  px_r, px_nxt;
  logic [VAL_W-1:0]  prev_r, prev_nxt;
  logic [VAL_W-1:0]  x0_r, x0_nxt;
  logic [VAL_W-1:0]  x1_r, x1_nxt;
  logic [VAL_W-1:0]  y0_r, y0_nxt;
  logic [AW-1:0]     sel_r, sel_nxt;
  logic              oor_r, oor_nxt;
  logic              neg_r, neg_nxt;
  logic [VAL_W-1:0]  mag_r, mag_nxt;
  logic [VAL_W-1:0]  t_r, t_nxt;
  logic [VAL_W-1:0]  dx_r, dx_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [VAL_W-1:0]  lo_r, lo_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic              out_oor_r, out_oor_nxt;
  logic [AW-1:0]     out_int_r, out_int_nxt;

  // Combinational helpers.
  logic [CNT_W-1:0]   n_pts;
  logic               in_xfer;
  logic               load_we;
  logic               issue;
  logic [AW-1:0]      ord_ra;
  logic               hit;
  logic               out_free;
  logic [VAL_W:0]     dy_w;
  logic [VAL_W:0]     dx_w;
  logic [VAL_W:0]     t_w;
  logic [2*VAL_W-1:0] prod_w;
  logic [VAL_W:0]     rem_sh;
  logic [VAL_W+1:0]   diff_w;
  logic               ge_w;
  logic [VAL_W+1:0]   term_w;
  logic [VAL_W+1:0]   sum_w;
  logic [VAL_W-1:0]   sat_w;

  // Points in use, saturated to the table size.
  always_comb begin
    if (CNT_W'(pin_r) > CNT_W'(MAX_POINTS)) begin
      n_pts = CNT_W'(MAX_POINTS);
    end else begin
      n_pts = CNT_W'(pin_r);
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign load_we  = in_xfer && (in_operation == OP_LOAD);
  assign issue    = (state_r == ST_SCAN) && (addr_r < n_pts);
  assign ord_ra   = (state_r == ST_RD1) ? sel_r + AW'(1) : sel_r;
  assign out_free = !out_valid_r || !out_stall;

  // Interval test on the entry returned by the memory.
  assign hit = rd_vld_r && (rd_idx_r != '0) &&
               ($signed(prev_r) <= $signed(px_r)) &&
               ($signed(px_r) <= $signed(ax_q));

  // Abscissa memory: one write port for loads, one read port for the scan.
  always_ff @(posedge clk) begin
    if (load_we) begin
      abscissa_mem[in_entry_index] <= in_point_x;
    end
    ax_q <= abscissa_mem[addr_r[AW-1:0]];
  end

  // Ordinate memory: written with the abscissa, read at both interval ends.
  always_ff @(posedge clk) begin
    if (load_we) begin
      ordinate_mem[in_entry_index] <= in_point_y;
    end
    oy_q <= ordinate_mem[ord_ra];
  end

  // Differences for the interpolation term.
  assign dy_w = {oy_q[VAL_W-1], oy_q} - {y0_r[VAL_W-1], y0_r};
  assign dx_w = {x1_r[VAL_W-1], x1_r} - {x0_r[VAL_W-1], x0_r};
  assign t_w  = {px_r[VAL_W-1], px_r} - {x0_r[VAL_W-1], x0_r};

  // Product of the magnitudes, both below 2^32.
  assign prod_w = mag_r * t_r;

  // One restoring division step.
  assign rem_sh = {rem_r, lo_r[VAL_W-1]};
  assign diff_w = {1'b0, rem_sh} - {2'b00, dx_r};
  assign ge_w   = !diff_w[VAL_W+1];

  // Final sum and saturation.
  assign term_w = neg_r ? -{2'b00, lo_r} : {2'b00, lo_r};
  assign sum_w  = {{2{y0_r[VAL_W-1]}}, y0_r} + term_w;
  always_comb begin
    priority if (!sum_w[VAL_W+1] && (sum_w[VAL_W] || sum_w[VAL_W-1])) begin
      sat_w = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sum_w[VAL_W+1] && (!sum_w[VAL_W] || !sum_w[VAL_W-1])) begin
      sat_w = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_w = sum_w[VAL_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    rd_vld_nxt    = issue;
    rd_idx_nxt    = addr_r[AW-1:0];
    px_nxt        = px_r;
    prev_nxt      = prev_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    sel_nxt       = sel_r;
    oor_nxt       = oor_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    t_nxt         = t_r;
    dx_nxt        = dx_r;
    rem_nxt       = rem_r;
    lo_nxt        = lo_r;
    dcnt_nxt      = dcnt_r;
    out_value_nxt = out_value_r;
    out_oor_nxt   = out_oor_r;
    out_int_nxt   = out_int_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (in_xfer && (in_operation == OP_QUERY)) begin
          px_nxt = in_point_x;
          if (n_pts < CNT_W'(2)) begin
            oor_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            oor_nxt   = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          addr_nxt = addr_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          prev_nxt = ax_q;
        end
        priority if (hit) begin
          x0_nxt    = prev_r;
          x1_nxt    = ax_q;
          sel_nxt   = rd_idx_r - AW'(1);
          state_nxt = ST_RD0;
        end else if (rd_vld_r && (CNT_W'(rd_idx_r) == n_pts - CNT_W'(1))) begin
          oor_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_RD0: begin
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        y0_nxt    = oy_q;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        neg_nxt   = dy_w[VAL_W];
        mag_nxt   = dy_w[VAL_W] ? VAL_W'(-dy_w) : dy_w[VAL_W-1:0];
        dx_nxt    = dx_w[VAL_W-1:0];
        t_nxt     = t_w[VAL_W-1:0];
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        dcnt_nxt = '0;
        if (dx_r == '0) begin
          // Zero-width interval answers with the lower value.
          lo_nxt    = '0;
          state_nxt = ST_FIN;
        end else begin
          rem_nxt   = prod_w[2*VAL_W-1:VAL_W];
          lo_nxt    = prod_w[VAL_W-1:0];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge_w ? diff_w[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        lo_nxt   = {lo_r[VAL_W-2:0], ge_w};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(VAL_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_oor_nxt   = oor_r;
          out_value_nxt = oor_r ? '0 : sat_w;
          out_int_nxt   = oor_r ? '0 : sel_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pin_r       <= CFG_W'(2);
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      dcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      addr_r      <= addr_nxt;
      dcnt_r      <= dcnt_nxt;
      if (cfg_wr_en) begin
        pin_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    px_r        <= px_nxt;
    prev_r      <= prev_nxt;
    x0_r        <= x0_nxt;
    x1_r        <= x1_nxt;
    y0_r        <= y0_nxt;
    sel_r       <= sel_nxt;
    oor_r       <= oor_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    t_r         <= t_nxt;
    dx_r        <= dx_nxt;
    rem_r       <= rem_nxt;
    lo_r        <= lo_nxt;
    out_value_r <= out_value_nxt;
    out_oor_r   <= out_oor_nxt;
    out_int_r   <= out_int_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_out_of_range = out_oor_r;
  assign out_interval     = out_int_r;

  // The divider never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dx_r != '0))
    else $error("division started with a zero divisor");

  // The partial remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < dx_r))
    else $error("division remainder out of bounds");

  // A query transfer always starts work.
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == OP_QUERY)) |=> (state_r != ST_IDLE))
    else $error("accepted query did not start");

  // An out-of-range result carries zero value and interval.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> ((out_value == '0) && (out_interval == '0)))
    else $error("out-of-range result has nonzero fields");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the piecewise linear interpolator. Loads
// supporting-point tables, queries inside, on and outside the intervals, and
// checks every result against an interpolation predictor kept in step with
// each accepted transfer. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import pli_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 95;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    out_of_range;
    logic [AW-1:0]           interval;
  } answer_t;

  // Mirror of the table and the point count, plus the answers still owed.
  class interp_checker;
    int unsigned             points;
    logic signed [VAL_W-1:0] abscissa[MAX_POINTS];
    logic signed [VAL_W-1:0] ordinate[MAX_POINTS];
    answer_t                 owed_answers[$];
    int                      errors;

    function new();
      points = 2;
      errors = 0;
      foreach (abscissa[i]) begin
        abscissa[i] = '0;
        ordinate[i] = '0;
      end
    endfunction

    // Scan the intervals in order and interpolate on the first enclosing one.
    function answer_t interpolate(logic signed [VAL_W-1:0] px);
      answer_t         ans;
      int              n;
      int              sel;
      bit              found;
      longint          x0, x1, y0, y1, dx, dy, t, res;
      longint unsigned mag, q;
      logic [127:0]    prod;
      ans   = '0;
      found = 1'b0;
      sel   = 0;
      n     = (points > MAX_POINTS) ? MAX_POINTS : int'(points);
      for (int k = 1; k < n && !found; k++) begin
        if (abscissa[k-1] <= px && px <= abscissa[k]) begin
          found = 1'b1;
          sel   = k - 1;
        end
      end
      if (!found) begin
        ans.out_of_range = 1'b1;
        return ans;
      end
      x0 = abscissa[sel];
      x1 = abscissa[sel+1];
      y0 = ordinate[sel];
      y1 = ordinate[sel+1];
      dx = x1 - x0;
      dy = y1 - y0;
      t  = longint'(px) - x0;
      if (dx == 0) begin
        res = y0;
      end else begin
        mag  = (dy < 0) ? -dy : dy;
        prod = 128'(mag) * 128'(t);
        q    = 64'(prod / 128'(dx));
        res  = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
      end
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      ans.value    = res[VAL_W-1:0];
      ans.interval = sel[AW-1:0];
      return ans;
    endfunction

    // A load updates the table; a query owes one answer.
    function void note_item(logic op, logic [AW-1:0] idx,
                            logic signed [VAL_W-1:0] x, logic signed [VAL_W-1:0] y);
      if (op == OP_LOAD) begin
        abscissa[idx] = x;
        ordinate[idx] = y;
      end else begin
        owed_answers.insert(owed_answers.size(), interpolate(x));
      end
    endfunction

    function void check_answer(logic signed [VAL_W-1:0] value, logic out_of_range,
                               logic [AW-1:0] interval);
      answer_t want;
      if (owed_answers.size() == 0) begin
        $display("%0t: unexpected result: value %0d out_of_range %0b interval %0d",
                 $time, value, out_of_range, interval);
        errors++;
        return;
      end
      want = owed_answers.pop_front();
      if (value !== want.value) begin
        $display("%0t: value mismatch: expected %0d, actual %0d", $time, want.value, value);
        errors++;
      end
      if (out_of_range !== want.out_of_range) begin
        $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                 $time, want.out_of_range, out_of_range);
        errors++;
      end
      if (interval !== want.interval) begin
        $display("%0t: interval mismatch: expected %0d, actual %0d",
                 $time, want.interval, interval);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [CFG_W-1:0]        cfg_wr_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_operation;
  logic [AW-1:0]           in_entry_index;
  logic signed [VAL_W-1:0] in_point_x;
  logic signed [VAL_W-1:0] in_point_y;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_out_of_range;
  logic [AW-1:0]           out_interval;

  interp_checker sb;
  bit            steady;
  bit            hold_request;
  int            idle_cycles;

  piecewise_linear_interpolator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_entry_index   (in_entry_index),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_out_of_range (out_out_of_range),
    .out_interval     (out_interval)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every result transfer against the oldest owed answer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_answer(out_value, out_out_of_range, out_interval);
    end
  end

  // End the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("piecewise_linear_interpolator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 17);
      end
    end
  end

  // Offer one item and return at the edge where it transfers. Valid stays
  // high unless a random gap follows.
  task automatic send_item(input logic op, input logic [AW-1:0] idx,
                           input logic signed [VAL_W-1:0] x,
                           input logic signed [VAL_W-1:0] y);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_entry_index <= idx;
    in_point_x     <= x;
    in_point_y     <= y;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, idx, x, y);
    if (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every owed answer, then let a load settle.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.owed_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_points(input logic [CFG_W-1:0] count);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.points = 32'(count);
  endtask

  // Load all entries with ascending abscissas; outside the full span some
  // steps are zero so that zero-width intervals occur.
  task automatic load_table(input bit full_span);
    longint                  xpos;
    logic signed [VAL_W-1:0] yv;
    int                      r;
    xpos = full_span ? -64'sd2147483648 : longint'($signed($urandom)) / 4;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (xpos > 64'sd2147483647) xpos = 64'sd2147483647;
      r  = $urandom_range(99);
      yv = (r < 10) ? 32'h7FFF_FFFF : (r < 20) ? 32'h8000_0000 : $urandom;
      send_item(OP_LOAD, i[AW-1:0], xpos[VAL_W-1:0], yv);
      if (full_span) begin
        xpos += 68174084;
      end else begin
        r = $urandom_range(99);
        if (r < 10)      xpos += 0;
        else if (r < 50) xpos += $urandom_range(255, 1);
        else if (r < 85) xpos += $urandom_range(1 << 20, 256);
        else             xpos += $urandom_range(1 << 26, 1 << 20);
      end
    end
  endtask

  // Mostly queries aimed at an interval of the table in use, with some
  // queries anywhere and some loads that disturb the table.
  task automatic random_item();
    int              r, n, k;
    longint          lo, hi, xq;
    longint unsigned span;
    r = $urandom_range(99);
    if (r < 8) begin
      send_item(OP_LOAD, AW'($urandom), $urandom, $urandom);
    end else if (r < 15) begin
      k = $urandom_range(MAX_POINTS - 1);
      send_item(OP_LOAD, k[AW-1:0], sb.abscissa[k], $urandom);
    end else if (r < 27) begin
      send_item(OP_QUERY, AW'($urandom), $urandom, $urandom);
    end else begin
      n  = (sb.points > MAX_POINTS) ? MAX_POINTS : int'(sb.points);
      k  = $urandom_range(n - 2, 0);
      lo = sb.abscissa[k];
      hi = sb.abscissa[k+1];
      r  = $urandom_range(9);
      if (r == 0 || hi <= lo) begin
        xq = lo;
      end else if (r == 1) begin
        xq = hi;
      end else begin
        span = hi - lo + 1;
        xq   = lo + longint'(64'({$urandom, $urandom}) % span);
      end
      send_item(OP_QUERY, AW'($urandom), xq[VAL_W-1:0], $urandom);
    end
  endtask

  initial begin
    int unsigned phase_points[8];
    phase_points = '{64, 127, 2, 65, 3, 100, 40, 64};
    sb             = new();
    steady         = 1'b0;
    hold_request   = 1'b0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_operation   = OP_LOAD;
    in_entry_index = '0;
    in_point_x     = '0;
    in_point_y     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Widest possible interval at the reset point count, both ends and middle.
    send_item(OP_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_LOAD, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_QUERY, 0, 32'h8000_0000, 0);
    send_item(OP_QUERY, 0, 32'h7FFF_FFFF, 0);
    send_item(OP_QUERY, 0, 32'h0000_0000, 0);
    send_item(OP_QUERY, 6'h3F, 32'h0000_0001, 32'hFFFF_FFFF);

    // Zero-width interval, then just outside it on both sides.
    send_item(OP_LOAD, 0, 32'h0005_0000, 100);
    send_item(OP_LOAD, 1, 32'h0005_0000, 200);
    send_item(OP_QUERY, 0, 32'h0005_0000, 0);
    send_item(OP_QUERY, 0, 32'h0005_0001, 0);
    send_item(OP_QUERY, 0, 32'h0004_FFFF, 0);

    // Descending pair: no interval can enclose the point.
    send_item(OP_LOAD, 1, 32'h0000_0000, 32'h0001_0000);
    send_item(OP_QUERY, 0, 32'h0002_0000, 0);
    send_item(OP_QUERY, 0, 32'h0005_0000, 0);

    // Too few points: every query is out of range.
    wait_results();
    write_points(0);
    send_item(OP_QUERY, 0, 32'h0002_0000, 0);
    wait_results();
    write_points(1);
    send_item(OP_QUERY, 0, 32'h0005_0000, 0);

    // Random phases across point counts, including saturation above the table.
    for (int p = 0; p < 8; p++) begin
      wait_results();
      write_points(phase_points[p][CFG_W-1:0]);
      if (p % 2 == 0) load_table(p % 4 == 0);
      if (p == 1) hold_request = 1'b1;
      if (p == 3) steady = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == 40) wait_results();
        random_item();
      end
      steady = 1'b0;
    end

    wait_results();
    if (sb.errors == 0 && sb.owed_answers.size() == 0) begin
      $display("piecewise_linear_interpolator test passed");
    end else begin
      $display("piecewise_linear_interpolator test failed");
    end
    $finish;
  end

endmodule
